### rtl/tksh_pkg.sv
// Package: types, constants and status codes for the top-k savings heap.
`timescale 1ns / 1ps
package tksh_pkg;
	localparam int TOP_ENTRIES = 16;
	localparam int NODES_PER_ENTRY = 8;
	localparam int SEQ_BYTES = 8;
	localparam int IW = $clog2(TOP_ENTRIES);
	localparam int SW = $clog2(NODES_PER_ENTRY);
	localparam int CW = $clog2(TOP_ENTRIES + 1);
	localparam int NCW = $clog2(NODES_PER_ENTRY + 1);
	localparam int SAVW = 35;
	// entry record: seq(64) len(4) freq(32) sav(35) count(4)
	localparam int EW = 64 + 4 + 32 + SAVW + 4;

	typedef enum logic [3:0] {
		ST_IGNORED  = 4'd0,
		ST_APPENDED = 4'd1,
		ST_LISTFULL = 4'd2,
		ST_INSERTED = 4'd3,
		ST_REPLACED = 4'd4,
		ST_BELOW    = 4'd5,
		ST_TOOLONG  = 4'd6,
		ST_READOK   = 4'd7,
		ST_READOOR  = 4'd8
	} status_t;

	typedef struct packed {
		logic [63:0]     seq;
		logic [3:0]      len;
		logic [31:0]     freq;
		logic [SAVW-1:0] sav;
		logic [3:0]      cnt;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_APPEND, S_NEW,
		S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_RD2, S_DN_CMP, S_SWAP2,
		S_READ_RD, S_READ_ID, S_OUT
	} state_t;
endpackage

### rtl/tksh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module tksh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/top_k_savings_heap.sv
// Top level: top-k savings min-heap with sequencer and entry/node-id memories.
//
// Usage:
//   One input channel (valid/stall) carries a command beat: cmd 0 offers a
//   sequence, cmd 1 reads heap entry read_index and node id read_slot.
//   One output channel (valid/stall) returns one result beat per command.
//   Items are handled one at a time. An offer scans the stored entries for a
//   duplicate, then sifts the new entry up or down level by level (up to 4
//   levels). An ignored or too-long offer goes straight to the result beat.
//   The duplicate scan walks the entry memory entry by entry through its
//   single read port.
//   The result waits in an output register while stall is high; the next
//   command is taken only once the result beat is delivered.
//   Reset clears the entry count and the sequencer; memory contents are
//   left as is and only entries below the count are ever used.
//   Node ids live in a second memory and stay with their entry on a swap
//   through an indirection: each heap slot holds a node-row pointer.
`timescale 1ns / 1ps
module top_k_savings_heap import tksh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [63:0] seq_bytes,
	input  logic [7:0]  seq_length,
	input  logic [31:0] frequency,
	input  logic [31:0] node_id,
	input  logic [3:0]  read_index,
	input  logic [2:0]  read_slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [4:0]  entry_count,
	output logic [34:0] min_savings,
	output logic [34:0] out_savings,
	output logic [3:0]  out_length,
	output logic [31:0] out_frequency,
	output logic [63:0] out_sequence,
	output logic [3:0]  out_node_count,
	output logic [31:0] out_node_id
);
	// entry memory word = entry record + node-row pointer
	localparam int MW = EW + IW;

	state_t state_q, state_nx;
	logic [CW-1:0] total_q;
	logic [IW-1:0] pos_q, oth_q, best_q;
	logic [CW-1:0] scan_q;
	entry_t new_q, cur_q, best_e_q;
	logic [IW-1:0] cur_row_q, best_row_q, new_row_q;
	logic [31:0] id_q;
	logic [SW-1:0] slot_q;
	logic [3:0] st_q;
	logic [SAVW-1:0] root_q;
	logic up_q, have_r_q;

	// row allocation: row pointers equal to original slot on fill order; on
	// replace the root's row is reused. Rows are assigned as slot index at insert.
	logic           e_we;
	logic [IW-1:0]  e_wa, e_ra;
	logic [MW-1:0]  e_wd, e_rd;
	logic           n_we;
	logic [IW+SW-1:0] n_wa, n_ra;
	logic [31:0]    n_wd, n_rd;

	tksh_ram #(.WIDTH(MW), .DEPTH(TOP_ENTRIES)) u_ent (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
	tksh_ram #(.WIDTH(32), .DEPTH(TOP_ENTRIES * NODES_PER_ENTRY)) u_ids (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));

	entry_t rd_e, wr_e;
	logic [IW-1:0] rd_row;
	assign rd_e = entry_t'(e_rd[MW-1:IW]);
	assign rd_row = e_rd[IW-1:0];
	assign wr_e = entry_t'(e_wd[MW-1:IW]);

	// input decode
	logic [63:0] mask;
	logic [3:0] len4;
	always_comb begin
		mask = '1;
		if (seq_length < 8'd8)
			mask = (64'd1 << {seq_length[2:0], 3'b000}) - 64'd1;
	end
	assign len4 = seq_length[3:0];

	logic accept;
	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign accept = in_valid && !in_stall;

	logic [IW-1:0] lch, rch, upi;
	logic [IW:0] lch_w, rch_w;
	assign upi = IW'((pos_q - 1'b1) >> 1);
	assign lch_w = {pos_q, 1'b1};
	assign rch_w = {pos_q, 1'b0} + (IW+1)'(2);
	assign lch = lch_w[IW-1:0];
	assign rch = rch_w[IW-1:0];
	logic l_ok, r_ok;
	assign l_ok = ({1'b0, lch_w} < (IW+2)'(total_q));
	assign r_ok = ({1'b0, rch_w} < (IW+2)'(total_q));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (accept) begin
				if (cmd)
					state_nx = S_READ_RD;
				else if (seq_length < 8'd2 || frequency <= 32'd1 ||
					seq_length > 8'(SEQ_BYTES))
					state_nx = S_OUT;
				else
					state_nx = S_SCAN_RD;
			end
			S_SCAN_RD: state_nx = (scan_q < total_q) ? S_SCAN_CMP : S_NEW;
			S_SCAN_CMP: begin
				if (rd_e.len == new_q.len && rd_e.seq == new_q.seq)
					state_nx = (rd_e.cnt < 4'(NODES_PER_ENTRY)) ? S_APPEND : S_OUT;
				else
					state_nx = S_SCAN_RD;
			end
			S_APPEND: state_nx = S_OUT;
			S_NEW: begin
				if (total_q < CW'(TOP_ENTRIES))
					state_nx = (total_q == '0) ? S_OUT : S_UP_RD;
				else if (new_q.sav > root_q)
					state_nx = S_DN_RD;
				else
					state_nx = S_OUT;
			end
			S_UP_RD: state_nx = S_UP_CMP;
			S_UP_CMP: state_nx = (new_q.sav < rd_e.sav) ? S_SWAP2 : S_OUT;
			S_DN_RD: state_nx = l_ok ? S_DN_RD2 : S_OUT;
			S_DN_RD2: state_nx = S_DN_CMP;
			S_DN_CMP: state_nx = S_SWAP2;
			S_SWAP2: begin
				if (up_q)
					state_nx = (pos_q == '0) ? S_OUT : S_UP_RD;
				else
					state_nx = (best_q == pos_q) ? S_OUT : S_DN_RD;
			end
			S_READ_RD: state_nx = S_READ_ID;
			S_READ_ID: state_nx = S_OUT;
			S_OUT: if (!out_valid) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// down-step compare results (left read at DN_RD2 edge, right at DN_CMP edge)
	logic dn_take_r;
	assign dn_take_r = have_r_q && (rd_e.sav < best_e_q.sav);

	always_comb begin
		e_we = 1'b0; e_wa = pos_q; e_wd = {new_q, new_row_q};
		e_ra = scan_q[IW-1:0];
		n_we = 1'b0; n_wa = {new_row_q, SW'(0)}; n_wd = id_q;
		n_ra = {cur_row_q, slot_q};
		unique case (state_q)
			S_SCAN_RD: e_ra = scan_q[IW-1:0];
			S_SCAN_CMP: ;
			S_APPEND: begin
				e_we = 1'b1; e_wa = oth_q;
				e_wd = {cur_q.seq, cur_q.len, cur_q.freq, cur_q.sav,
					cur_q.cnt + 4'd1, cur_row_q};
				n_we = 1'b1; n_wa = {cur_row_q, cur_q.cnt[SW-1:0]};
			end
			S_NEW: if (total_q < CW'(TOP_ENTRIES) || new_q.sav > root_q) begin
				e_we = 1'b1; n_we = 1'b1;
				e_wa = (total_q < CW'(TOP_ENTRIES)) ? total_q[IW-1:0] : '0;
			end
			S_UP_RD: e_ra = upi;
			S_DN_RD: e_ra = lch;
			S_DN_RD2: e_ra = rch;
			S_DN_CMP: begin
				e_we = 1'b1; e_wa = pos_q;
				e_wd = dn_take_r ? e_rd : {best_e_q, best_row_q};
			end
			S_SWAP2: begin
				e_we = 1'b1; e_wa = oth_q;
			end
			S_UP_CMP: if (new_q.sav < rd_e.sav) begin
				e_we = 1'b1; e_wa = pos_q; e_wd = e_rd;
			end
			S_READ_RD: e_ra = pos_q;
			S_READ_ID: n_ra = {rd_row, slot_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			out_valid <= 1'b0;
			root_q <= '0;
		end else begin
			state_q <= state_nx;
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (state_q == S_NEW && total_q < CW'(TOP_ENTRIES))
				total_q <= total_q + 1'b1;
			if (e_we && e_wa == '0)
				root_q <= wr_e.sav;
			if (state_q == S_OUT && !out_valid)
				out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				new_q.seq <= seq_bytes & mask;
				new_q.len <= len4;
				new_q.freq <= frequency;
				new_q.sav <= SAVW'({27'd0, seq_length} * {3'd0, frequency});
				new_q.cnt <= 4'd1;
				id_q <= node_id;
				scan_q <= '0;
				pos_q <= read_index;
				slot_q <= read_slot;
				st_q <= cmd ? ST_READOK :
					(seq_length < 8'd2 || frequency <= 32'd1) ? ST_IGNORED : ST_TOOLONG;
				out_savings <= '0; out_length <= '0; out_frequency <= '0;
				out_sequence <= '0; out_node_count <= '0; out_node_id <= '0;
			end
			S_SCAN_RD: oth_q <= scan_q[IW-1:0];
			S_SCAN_CMP: begin
				cur_q <= rd_e; cur_row_q <= rd_row;
				scan_q <= scan_q + 1'b1;
				if (rd_e.len == new_q.len && rd_e.seq == new_q.seq)
					st_q <= (rd_e.cnt < 4'(NODES_PER_ENTRY)) ? ST_APPENDED : ST_LISTFULL;
			end
			S_APPEND: ;
			S_NEW: begin
				up_q <= (total_q < CW'(TOP_ENTRIES));
				if (total_q < CW'(TOP_ENTRIES)) begin
					st_q <= ST_INSERTED; pos_q <= total_q[IW-1:0];
				end else if (new_q.sav > root_q) begin
					st_q <= ST_REPLACED; pos_q <= '0;
				end else
					st_q <= ST_BELOW;
			end
			S_UP_RD: oth_q <= upi;
			S_UP_CMP: if (new_q.sav < rd_e.sav) begin
				pos_q <= oth_q; oth_q <= oth_q;
			end
			S_DN_RD: begin
				best_q <= pos_q; have_r_q <= r_ok;
				best_e_q <= new_q; best_row_q <= new_row_q;
			end
			S_DN_RD2: if (rd_e.sav < new_q.sav) begin
				best_q <= lch; best_e_q <= rd_e; best_row_q <= rd_row;
			end
			S_DN_CMP: begin
				if (dn_take_r) begin
					oth_q <= rch; best_q <= rch;
				end else
					oth_q <= best_q;
			end
			S_SWAP2: if (!up_q) pos_q <= best_q;
			S_READ_RD: ;
			S_READ_ID: if (pos_q < total_q[IW-1:0] || total_q == CW'(TOP_ENTRIES)) begin
				if ({1'b0, pos_q} < total_q) begin
					out_savings <= rd_e.sav; out_length <= rd_e.len;
					out_frequency <= rd_e.freq; out_sequence <= rd_e.seq;
					out_node_count <= rd_e.cnt;
				end else st_q <= ST_READOOR;
			end else st_q <= ST_READOOR;
			S_OUT: ;
			default: ;
		endcase
		if (state_q == S_OUT && !out_valid) begin
			status <= st_q;
			entry_count <= total_q;
			min_savings <= (total_q == '0) ? '0 : root_q;
			if (st_q == ST_READOK && {1'b0, slot_q} < out_node_count)
				out_node_id <= n_rd;
		end
	end

	// row pointer of a fresh entry: its slot on insert, root's row on replace
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN_CMP && scan_q == '0)
			new_row_q <= (total_q < CW'(TOP_ENTRIES)) ? total_q[IW-1:0] : rd_row;
		if (state_q == S_SCAN_RD && total_q == '0)
			new_row_q <= '0;
	end
endmodule
